// ----- src/tss_pkg.sv -----
`timescale 1ns / 1ps
package tss_pkg;

  localparam int AtabLen  = 24;
  localparam int ZW       = 27;
  localparam int AngleMax = 51472;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_INV_CELL_X   = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_INV_CELL_Y   = 8'd3;

  typedef logic signed [ZW-1:0] zval_t;

  // atan(2^-i) in Q.24
  localparam zval_t ATAN_Q24 [AtabLen] = '{
    27'sd13176795, 27'sd7778716, 27'sd4110060, 27'sd2086331, 27'sd1047214, 27'sd524118,
    27'sd262123, 27'sd131069, 27'sd65536, 27'sd32768, 27'sd16384, 27'sd8192,
    27'sd4096, 27'sd2048, 27'sd1024, 27'sd512, 27'sd256, 27'sd128,
    27'sd64, 27'sd32, 27'sd16, 27'sd8, 27'sd4, 27'sd2
  };

  typedef struct packed {
    logic [15:0] row;
    logic [11:0] col;
    logic        last;
    logic        frame;
  } meta_t;

  function automatic longint shr_tz(input longint v, input int s);
    longint r;
    if (v < 0) begin
      r = -((-v) >>> s);
    end else begin
      r = v >>> s;
    end
    return r;
  endfunction

  // Unit vector run through the vectoring rotation: gain-scaled 1.0 in Q.27.
  function automatic longint unit_gain(input int stages);
    longint x;
    longint y;
    longint tx;
    x = longint'(1) <<< 27;
    y = 0;
    for (int i = 0; i < stages && i < AtabLen; i++) begin
      tx = x;
      if (y >= 0) begin
        x = x + shr_tz(y, i);
        y = y - shr_tz(tx, i);
      end else begin
        x = x - shr_tz(y, i);
        y = y + shr_tz(tx, i);
      end
    end
    return x;
  endfunction

endpackage

// ----- src/tss_if.sv -----
`timescale 1ns / 1ps
interface tss_elev_if #(
  parameter int ElevBits = 24
) ();
  logic                       valid;
  logic                       ready;
  logic signed [ElevBits-1:0] elevation;
  modport source (output valid, output elevation, input ready);
  modport sink (input valid, input elevation, output ready);
endinterface

interface tss_slope_if ();
  logic        valid;
  logic        ready;
  logic [15:0] slope_angle;
  logic [15:0] out_row;
  logic [11:0] out_col;
  logic        last_of_run;
  logic        frame_done;
  modport source (output valid, output slope_angle, output out_row, output out_col,
                  output last_of_run, output frame_done, input ready);
  modport sink (input valid, input slope_angle, input out_row, input out_col,
                input last_of_run, input frame_done, output ready);
endinterface

interface tss_cfg_if ();
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- src/terrain_slope_sobel.sv -----
`timescale 1ns / 1ps
// Streaming terrain slope: a raster of signed Q16.8 elevations goes in, one Q1.15 slope
// angle per pixel comes out with its row and column, one row and one column behind the
// input. Each input item passes a line store read, then a window update, then one issue
// step for each result it releases (zero to four), and no new item is taken until the
// last result is issued; the result issue loop of the window sequencer sets this. Results
// then pass a two-stage split multiply, two chains of CORDIC_STAGES rotation cells and
// an output register. A stalled output holds the whole pipeline in place.
// Configure the size and cell spacing only while the block is idle.
module terrain_slope_sobel
  import tss_pkg::*;
#(
  parameter int MAX_WIDTH     = 4096,
  parameter int ELEV_BITS     = 24,
  parameter int CORDIC_STAGES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tss_cfg_if.sink   cfg,
  tss_elev_if.sink  elev_in,
  tss_slope_if.source slope_out
);

  localparam int AW = ELEV_BITS + 2;
  localparam int PW = AW + 12;
  localparam int WC = ELEV_BITS + 31;
  localparam longint OneK = unit_gain(CORDIC_STAGES);

  logic [12:0] width_q;
  logic [15:0] height_q;
  logic [23:0] inv_x_q, inv_y_q;
  logic        cfg_acc;
  logic        en;

  logic          v0;
  logic [AW-1:0] gxa, gya;
  meta_t         m0;

  logic          v1_q, v2_q;
  logic [PW-1:0] pxl_q, pxh_q, pyl_q, pyh_q;
  meta_t         m1_q, m2_q;
  logic signed [WC-1:0] x2_q, y2_q;

  logic                 c1v [CORDIC_STAGES+1];
  logic signed [WC-1:0] c1x [CORDIC_STAGES+1];
  logic signed [WC-1:0] c1y [CORDIC_STAGES+1];
  zval_t                c1z [CORDIC_STAGES+1];
  meta_t                c1m [CORDIC_STAGES+1];
  logic                 c2v [CORDIC_STAGES+1];
  logic signed [WC-1:0] c2x [CORDIC_STAGES+1];
  logic signed [WC-1:0] c2y [CORDIC_STAGES+1];
  zval_t                c2z [CORDIC_STAGES+1];
  meta_t                c2m [CORDIC_STAGES+1];

  zval_t       zf;
  logic [ZW-1:0] zr;
  logic [15:0] ang;

  logic        out_valid_q;
  logic [15:0] angle_q;
  meta_t       out_meta_q;

  assign cfg.ready = 1'b1;
  assign cfg_acc   = cfg.valid && cfg.ready;
  assign en        = !out_valid_q || slope_out.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd4096;
      height_q <= 16'd1024;
      inv_x_q  <= 24'd65536;
      inv_y_q  <= 24'd65536;
    end else if (cfg_acc) begin
      case (cfg.index)
        REG_IMAGE_WIDTH:  width_q  <= cfg.data[12:0];
        REG_IMAGE_HEIGHT: height_q <= cfg.data[15:0];
        REG_INV_CELL_X:   inv_x_q  <= cfg.data[23:0];
        REG_INV_CELL_Y:   inv_y_q  <= cfg.data[23:0];
        default: ;
      endcase
    end
  end

  tss_window #(
    .MaxWidth (MAX_WIDTH),
    .ElevBits (ELEV_BITS)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .elev_in  (elev_in),
    .width_i  (width_q),
    .height_i (height_q),
    .en_i     (en),
    .valid_o  (v0),
    .gx_abs_o (gxa),
    .gy_abs_o (gya),
    .meta_o   (m0)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= v0;
      v2_q        <= v1_q;
      out_valid_q <= c2v[CORDIC_STAGES];
    end
  end

  // split multiply: low and high halves of the reciprocal, registered, then summed in the next register stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      pxl_q      <= PW'(gxa) * PW'(inv_x_q[11:0]);
      pxh_q      <= PW'(gxa) * PW'(inv_x_q[23:12]);
      pyl_q      <= PW'(gya) * PW'(inv_y_q[11:0]);
      pyh_q      <= PW'(gya) * PW'(inv_y_q[23:12]);
      m1_q       <= m0;
      x2_q       <= $signed(WC'(pxl_q) + (WC'(pxh_q) << 12));
      y2_q       <= $signed(WC'(pyl_q) + (WC'(pyh_q) << 12));
      m2_q       <= m1_q;
      angle_q    <= ang;
      out_meta_q <= c2m[CORDIC_STAGES];
    end
  end

  assign c1v[0] = v2_q;
  assign c1x[0] = x2_q;
  assign c1y[0] = y2_q;
  assign c1z[0] = '0;
  assign c1m[0] = m2_q;

  // second run: gain-scaled unit against the gain-scaled magnitude
  assign c2v[0] = c1v[CORDIC_STAGES];
  assign c2x[0] = WC'(OneK);
  assign c2y[0] = c1x[CORDIC_STAGES];
  assign c2z[0] = '0;
  assign c2m[0] = c1m[CORDIC_STAGES];

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cells
    tss_cordic_cell #(.W(WC), .Idx(i)) u_mag (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (c1v[i]),
      .x_i     (c1x[i]),
      .y_i     (c1y[i]),
      .z_i     (c1z[i]),
      .meta_i  (c1m[i]),
      .valid_o (c1v[i+1]),
      .x_o     (c1x[i+1]),
      .y_o     (c1y[i+1]),
      .z_o     (c1z[i+1]),
      .meta_o  (c1m[i+1])
    );
    tss_cordic_cell #(.W(WC), .Idx(i)) u_ang (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (c2v[i]),
      .x_i     (c2x[i]),
      .y_i     (c2y[i]),
      .z_i     (c2z[i]),
      .meta_i  (c2m[i]),
      .valid_o (c2v[i+1]),
      .x_o     (c2x[i+1]),
      .y_o     (c2y[i+1]),
      .z_o     (c2z[i+1]),
      .meta_o  (c2m[i+1])
    );
  end

  // clamp at zero, round half up to Q.15, saturate at pi/2
  always_comb begin
    zf = c2z[CORDIC_STAGES];
    zr = (zf[ZW-1] ? '0 : ZW'(zf) + ZW'(256)) >> 9;
    ang = (zr > ZW'(AngleMax)) ? 16'(AngleMax) : 16'(zr);
  end

  assign slope_out.valid       = out_valid_q;
  assign slope_out.slope_angle = angle_q;
  assign slope_out.out_row     = out_meta_q.row;
  assign slope_out.out_col     = out_meta_q.col;
  assign slope_out.last_of_run = out_meta_q.last;
  assign slope_out.frame_done  = out_meta_q.frame;

  a_frame_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_meta_q.frame |-> out_meta_q.last)
    else $error("frame_done without last_of_run");

  a_angle_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> angle_q <= 16'(AngleMax))
    else $error("slope angle above pi/2");

  a_one_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    elev_in.valid && elev_in.ready |=> !elev_in.ready)
    else $error("second request taken while the first is in the window");

endmodule

// ----- src/tss_cordic_cell.sv -----
`timescale 1ns / 1ps
module tss_cordic_cell
  import tss_pkg::*;
#(
  parameter int W   = 55,
  parameter int Idx = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic signed [W-1:0] x_i,
  input  logic signed [W-1:0] y_i,
  input  zval_t               z_i,
  input  meta_t               meta_i,
  output logic                valid_o,
  output logic signed [W-1:0] x_o,
  output logic signed [W-1:0] y_o,
  output zval_t               z_o,
  output meta_t               meta_o
);

  logic                valid_q;
  logic signed [W-1:0] x_q, x_d, y_q, y_d;
  zval_t               z_q, z_d;
  meta_t               meta_q;

  // shift toward zero
  function automatic logic signed [W-1:0] shr(input logic signed [W-1:0] v);
    logic signed [W-1:0] m;
    m = -v;
    if (v[W-1]) begin
      return -(m >>> Idx);
    end
    return v >>> Idx;
  endfunction

  always_comb begin
    if (!y_i[W-1]) begin
      x_d = x_i + shr(y_i);
      y_d = y_i - shr(x_i);
      z_d = z_i + ATAN_Q24[Idx];
    end else begin
      x_d = x_i - shr(y_i);
      y_d = y_i + shr(x_i);
      z_d = z_i - ATAN_Q24[Idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      meta_q <= meta_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign meta_o  = meta_q;

endmodule

// ----- src/tss_window.sv -----
`timescale 1ns / 1ps
module tss_window
  import tss_pkg::*;
#(
  parameter int MaxWidth = 4096,
  parameter int ElevBits = 24
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tss_elev_if.sink            elev_in,
  input  logic [12:0]         width_i,
  input  logic [15:0]         height_i,
  input  logic                en_i,
  output logic                valid_o,
  output logic [ElevBits+1:0] gx_abs_o,
  output logic [ElevBits+1:0] gy_abs_o,
  output meta_t               meta_o
);

  localparam int CW = $clog2(MaxWidth);
  localparam int GW = ElevBits + 3;
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  typedef logic signed [ElevBits-1:0] elev_t;

  logic [1:0]    state_q, state_d;
  logic [CW-1:0] col_q, jc_q;
  logic [15:0]   row_q, jr_q;
  logic [3:0]    jobs_q, jobs_d, jobs_left;
  elev_t         v_q, up_rd_q, mid_rd_q;
  elev_t         win_q [3][3];
  elev_t         upper_mem [MaxWidth];
  elev_t         middle_mem [MaxWidth];
  logic          acc, issue;

  logic [15:0]   w_eff, h_eff;
  logic          last_col, last_row;
  logic [1:0]    sel;
  logic          br, bc, top_out, left_out;
  elev_t         nb [3][3];
  elev_t         ctr;
  logic signed [GW-1:0] gx, gy;
  meta_t         meta_d;

  logic                valid_q;
  logic [ElevBits+1:0] gxa_q, gya_q;
  meta_t               meta_q;

  assign acc           = elev_in.valid && elev_in.ready;
  assign elev_in.ready = (state_q == ST_IDLE);

  always_comb begin
    if (width_i == 13'd0) begin
      w_eff = 16'd1;
    end else if (16'(width_i) > 16'(MaxWidth)) begin
      w_eff = 16'(MaxWidth);
    end else begin
      w_eff = 16'(width_i);
    end
    h_eff    = (height_i == 16'd0) ? 16'd1 : height_i;
    last_col = 16'(col_q) >= (w_eff - 16'd1);
    last_row = row_q >= (h_eff - 16'd1);
    jobs_d   = {last_col && last_row, last_col && (row_q != 16'd0),
                (col_q != '0) && last_row, (col_q != '0) && (row_q != 16'd0)};
  end

  // lowest pending job first: left column before right, upper row before lower
  always_comb begin
    if (jobs_q[0]) begin
      sel = 2'd0;
    end else if (jobs_q[1]) begin
      sel = 2'd1;
    end else if (jobs_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
    jobs_left = jobs_q & ~(4'b0001 << sel);
  end

  assign issue = (state_q == ST_EMIT) && en_i;

  always_comb begin
    br       = sel[0];
    bc       = sel[1];
    top_out  = br ? (jr_q == 16'd0) : (jr_q == 16'd1);
    left_out = bc ? (jc_q == '0) : (jc_q == CW'(1));
    ctr      = win_q[{1'b0, br} + 2'd1][{1'b0, bc} + 2'd1];
    for (int m = 0; m < 3; m++) begin
      for (int k = 0; k < 3; k++) begin
        logic [1:0] rr;
        logic [1:0] cc;
        logic       outside;
        rr = 2'(m) + {1'b0, br};
        cc = 2'(k) + {1'b0, bc};
        outside = (m == 0 && top_out) || (m == 2 && br) || (k == 0 && left_out) ||
                  (k == 2 && bc) || (rr == 2'd3) || (cc == 2'd3);
        nb[m][k] = outside ? ctr : win_q[(rr == 2'd3) ? 2'd2 : rr][(cc == 2'd3) ? 2'd2 : cc];
      end
    end
    gx = GW'(nb[0][2]) + (GW'(nb[1][2]) <<< 1) + GW'(nb[2][2])
       - GW'(nb[0][0]) - (GW'(nb[1][0]) <<< 1) - GW'(nb[2][0]);
    gy = GW'(nb[2][0]) + (GW'(nb[2][1]) <<< 1) + GW'(nb[2][2])
       - GW'(nb[0][0]) - (GW'(nb[0][1]) <<< 1) - GW'(nb[0][2]);
    meta_d.row   = br ? jr_q : jr_q - 16'd1;
    meta_d.col   = 12'(bc ? jc_q : jc_q - CW'(1));
    meta_d.last  = (jobs_left == 4'd0);
    meta_d.frame = (sel == 2'd3);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (acc) state_d = ST_LOAD;
      ST_LOAD: state_d = (jobs_d != 4'd0) ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (en_i && jobs_left == 4'd0) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      col_q   <= '0;
      row_q   <= '0;
      jobs_q  <= '0;
      valid_q <= 1'b0;
      for (int m = 0; m < 3; m++) begin
        for (int k = 0; k < 3; k++) begin
          win_q[m][k] <= '0;
        end
      end
    end else begin
      state_q <= state_d;
      if (en_i) begin
        valid_q <= issue;
      end
      if (state_q == ST_LOAD) begin
        jobs_q <= jobs_d;
        for (int m = 0; m < 3; m++) begin
          win_q[m][0] <= win_q[m][1];
          win_q[m][1] <= win_q[m][2];
        end
        win_q[0][2] <= up_rd_q;
        win_q[1][2] <= mid_rd_q;
        win_q[2][2] <= v_q;
        if (last_col) begin
          col_q <= '0;
          row_q <= last_row ? 16'd0 : row_q + 16'd1;
        end else begin
          col_q <= col_q + CW'(1);
        end
      end else if (issue) begin
        jobs_q <= jobs_left;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      v_q      <= elev_in.elevation;
      up_rd_q  <= upper_mem[col_q];
      mid_rd_q <= middle_mem[col_q];
    end
    if (state_q == ST_LOAD) begin
      upper_mem[col_q]  <= mid_rd_q;
      middle_mem[col_q] <= v_q;
      jc_q              <= col_q;
      jr_q              <= row_q;
    end
    if (en_i) begin
      gxa_q  <= (ElevBits + 2)'(gx[GW-1] ? -gx : gx);
      gya_q  <= (ElevBits + 2)'(gy[GW-1] ? -gy : gy);
      meta_q <= meta_d;
    end
  end

  assign valid_o  = valid_q;
  assign gx_abs_o = gxa_q;
  assign gy_abs_o = gya_q;
  assign meta_o   = meta_q;

endmodule
